// ===== rtl/tdcl_pkg.sv =====
`default_nettype none

package tdcl_pkg;

  localparam int TICKS_PER_MS = 4;
  localparam int CODE_LENGTH  = 3;

  localparam int DIGIT_W     = 4;
  localparam int MS_W        = 16;
  localparam int LAMP_W      = 8;
  localparam int POS_W       = 2;
  localparam int ROUND_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PRESCALE_W  = $clog2(TICKS_PER_MS + 1);

  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd8;
  localparam logic [ROUND_W-1:0] FLASH_ROUNDS = 2'd3;
  localparam logic [LAMP_W-1:0]  ALL_LIT      = 8'hFF;
  localparam logic [LAMP_W-1:0]  ALL_DARK     = 8'h00;

  localparam logic [MS_W-1:0] DEBOUNCE_MS_RST = 16'd250;
  localparam logic [MS_W-1:0] OPEN_MS_RST     = 16'd3000;
  localparam logic [MS_W-1:0] PAUSE_MS_RST    = 16'd1000;
  localparam logic [MS_W-1:0] FLASH_MS_RST    = 16'd10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_MS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MS    = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_DEB_SELECT = 3'd1,
    MODE_DEB_ENTER  = 3'd2,
    MODE_OPEN       = 3'd3,
    MODE_REJ_DARK   = 3'd4,
    MODE_REJ_FLASH  = 3'd5,
    MODE_REJ_PAUSE  = 3'd6
  } mode_t;

  // lamp i lit when the digit is above i
  function automatic logic [LAMP_W-1:0] thermometer(input logic [DIGIT_W-1:0] d);
    logic [LAMP_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < LAMP_W; i++) begin
      bits[i] = (d > DIGIT_W'(i));
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdcl_in_if.sv =====
`default_nettype none

interface tdcl_in_if;
  logic valid;
  logic ready;
  logic select_pressed;
  logic enter_pressed;

  modport source (output valid, output select_pressed, output enter_pressed, input ready);
  modport sink   (input valid, input select_pressed, input enter_pressed, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdcl_out_if.sv =====
`default_nettype none

interface tdcl_out_if;
  logic                          valid;
  logic                          ready;
  logic [tdcl_pkg::LAMP_W-1:0]   lamps;
  logic                          unlocked;
  logic                          rejecting;
  logic [tdcl_pkg::POS_W-1:0]    digits_entered;
  logic [tdcl_pkg::DIGIT_W-1:0]  current_digit;

  modport source (output valid, output lamps, output unlocked, output rejecting,
                  output digits_entered, output current_digit, input ready);
  modport sink   (input valid, input lamps, input unlocked, input rejecting,
                  input digits_entered, input current_digit, output ready);
endinterface

`default_nettype wire

// ===== rtl/three_digit_code_lock.sv =====
// Three-digit combination lock, stepped by a timer tick.
// in_if  : one item per timer tick, carrying the sampled select and enter buttons.
// out_if : one item per accepted tick: lamps, unlocked, rejecting, digits
//          entered so far and the digit currently selected.
// cfg_*  : write-only register port (code digits and the four delays in ms);
//          write only while no tick item is outstanding.
// Each tick updates the lock state in the cycle it is accepted and its item is
// held in the output register from the next cycle on; the lock takes one item
// per cycle while the receiver does not stall. The only loop is the state update
// (prescaler compare/decrement and the ms down-counter).
// in_if.ready is high while the output register is empty or being drained,
// so a stalled receiver holds exactly one item and back-pressures the ticks.
// Delays count TICKS_PER_MS ticks per ms; buttons are ignored while one runs.
// Reset (rst_n low, synchronous) returns the lock to idle with lamps dark and
// the registers to their defaults, and empties the output register.
`default_nettype none

module three_digit_code_lock (
  input  wire                               clk,
  input  wire                               rst_n,
  tdcl_in_if.sink                           in_if,
  tdcl_out_if.source                        out_if,
  input  wire                               cfg_we,
  input  wire [tdcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [tdcl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DW = tdcl_pkg::DIGIT_W;
  localparam int MW = tdcl_pkg::MS_W;
  localparam int PW = tdcl_pkg::PRESCALE_W;
  localparam int NE = tdcl_pkg::CODE_LENGTH - 1;

  // configuration
  logic [DW-1:0] code_r [tdcl_pkg::CODE_LENGTH];
  logic [MW-1:0] debounce_ms_r, open_ms_r, pause_ms_r, flash_ms_r;

  // lock state
  tdcl_pkg::mode_t                 mode_r, mode_nxt;
  logic [PW-1:0]                   prescale_r, prescale_nxt;
  logic [MW-1:0]                   remain_r, remain_nxt;
  logic [DW-1:0]                   selected_r, selected_nxt;
  logic [tdcl_pkg::POS_W-1:0]      position_r, position_nxt;
  // the last digit is compared straight from the selection, never stored
  logic [DW-1:0]                   entered_r [NE];
  logic [DW-1:0]                   entered_nxt [NE];
  logic [tdcl_pkg::ROUND_W-1:0]    round_r, round_nxt;
  logic [tdcl_pkg::LAMP_W-1:0]     lamp_r, lamp_nxt;

  // output register
  logic                            out_valid_r;
  logic [tdcl_pkg::LAMP_W-1:0]     out_lamps_r;
  logic                            out_unlocked_r;
  logic                            out_rejecting_r;
  logic [tdcl_pkg::POS_W-1:0]      out_digits_r;
  logic [DW-1:0]                   out_digit_r;

  logic accept;
  logic match;
  logic [tdcl_pkg::ROUND_W-1:0] round_inc;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    match = (selected_r == code_r[tdcl_pkg::CODE_LENGTH-1]);
    for (int i = 0; i < NE; i++) begin
      if (entered_r[i] != code_r[i]) match = 1'b0;
    end
  end

  assign round_inc = round_r + tdcl_pkg::ROUND_W'(1);

  always_comb begin
    mode_nxt     = mode_r;
    prescale_nxt = prescale_r;
    remain_nxt   = remain_r;
    selected_nxt = selected_r;
    position_nxt = position_r;
    entered_nxt  = entered_r;
    round_nxt    = round_r;
    lamp_nxt     = lamp_r;

    if (mode_r == tdcl_pkg::MODE_IDLE) begin
      if (in_if.select_pressed) begin
        mode_nxt     = tdcl_pkg::MODE_DEB_SELECT;
        prescale_nxt = PW'(tdcl_pkg::TICKS_PER_MS);
        remain_nxt   = debounce_ms_r;
      end else if (in_if.enter_pressed) begin
        mode_nxt     = tdcl_pkg::MODE_DEB_ENTER;
        prescale_nxt = PW'(tdcl_pkg::TICKS_PER_MS);
        remain_nxt   = debounce_ms_r;
      end
    end else if (prescale_r > PW'(1)) begin
      prescale_nxt = prescale_r - PW'(1);
    end else begin
      prescale_nxt = PW'(tdcl_pkg::TICKS_PER_MS);
      if (remain_r > MW'(1)) begin
        remain_nxt = remain_r - MW'(1);
      end else begin
        // delay ends: take the completion action
        remain_nxt = '0;
        case (mode_r)
          tdcl_pkg::MODE_DEB_SELECT: begin
            selected_nxt = (selected_r < tdcl_pkg::DIGIT_MAX) ? selected_r + DW'(1) : '0;
            mode_nxt     = tdcl_pkg::MODE_IDLE;
            lamp_nxt     = tdcl_pkg::thermometer(selected_nxt);
          end
          tdcl_pkg::MODE_DEB_ENTER: begin
            selected_nxt = '0;
            if (position_r == tdcl_pkg::POS_W'(tdcl_pkg::CODE_LENGTH - 1)) begin
              position_nxt = '0;
              for (int i = 0; i < NE; i++) entered_nxt[i] = '0;
              if (match) begin
                mode_nxt = tdcl_pkg::MODE_OPEN;
                remain_nxt = open_ms_r;
                lamp_nxt = tdcl_pkg::ALL_LIT;
              end else begin
                round_nxt = '0;
                mode_nxt = tdcl_pkg::MODE_REJ_DARK;
                remain_nxt = pause_ms_r;
                lamp_nxt = tdcl_pkg::ALL_DARK;
              end
            end else begin
              for (int i = 0; i < NE; i++) begin
                if (position_r == tdcl_pkg::POS_W'(i)) entered_nxt[i] = selected_r;
              end
              position_nxt = position_r + tdcl_pkg::POS_W'(1);
              mode_nxt     = tdcl_pkg::MODE_IDLE;
              lamp_nxt     = tdcl_pkg::thermometer('0);
            end
          end
          tdcl_pkg::MODE_REJ_DARK: begin
            mode_nxt   = tdcl_pkg::MODE_REJ_FLASH;
            remain_nxt = flash_ms_r;
            lamp_nxt   = tdcl_pkg::ALL_LIT;
          end
          tdcl_pkg::MODE_REJ_FLASH: begin
            mode_nxt   = tdcl_pkg::MODE_REJ_PAUSE;
            remain_nxt = pause_ms_r;
            lamp_nxt   = tdcl_pkg::ALL_DARK;
          end
          tdcl_pkg::MODE_REJ_PAUSE: begin
            if (round_inc < tdcl_pkg::FLASH_ROUNDS) begin
              round_nxt  = round_inc;
              mode_nxt   = tdcl_pkg::MODE_REJ_FLASH;
              remain_nxt = flash_ms_r;
              lamp_nxt   = tdcl_pkg::ALL_LIT;
            end else begin
              round_nxt = '0;
              mode_nxt  = tdcl_pkg::MODE_IDLE;
              lamp_nxt  = tdcl_pkg::thermometer(selected_r);
            end
          end
          default: begin
            // open display ends
            mode_nxt = tdcl_pkg::MODE_IDLE;
            lamp_nxt = tdcl_pkg::thermometer(selected_r);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tdcl_pkg::CODE_LENGTH; i++) code_r[i] <= '0;
      debounce_ms_r <= tdcl_pkg::DEBOUNCE_MS_RST;
      open_ms_r     <= tdcl_pkg::OPEN_MS_RST;
      pause_ms_r    <= tdcl_pkg::PAUSE_MS_RST;
      flash_ms_r    <= tdcl_pkg::FLASH_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tdcl_pkg::CFG_CODE_FIRST:  code_r[0] <= cfg_wdata[DW-1:0];
        tdcl_pkg::CFG_CODE_SECOND: code_r[1] <= cfg_wdata[DW-1:0];
        tdcl_pkg::CFG_CODE_THIRD:  code_r[2] <= cfg_wdata[DW-1:0];
        tdcl_pkg::CFG_DEBOUNCE_MS: debounce_ms_r <= cfg_wdata[MW-1:0];
        tdcl_pkg::CFG_OPEN_MS:     open_ms_r     <= cfg_wdata[MW-1:0];
        tdcl_pkg::CFG_PAUSE_MS:    pause_ms_r    <= cfg_wdata[MW-1:0];
        tdcl_pkg::CFG_FLASH_MS:    flash_ms_r    <= cfg_wdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= tdcl_pkg::MODE_IDLE;
      prescale_r <= PW'(tdcl_pkg::TICKS_PER_MS);
      remain_r   <= '0;
      selected_r <= '0;
      position_r <= '0;
      for (int i = 0; i < NE; i++) entered_r[i] <= '0;
      round_r    <= '0;
      lamp_r     <= tdcl_pkg::ALL_DARK;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      prescale_r <= prescale_nxt;
      remain_r   <= remain_nxt;
      selected_r <= selected_nxt;
      position_r <= position_nxt;
      entered_r  <= entered_nxt;
      round_r    <= round_nxt;
      lamp_r     <= lamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_lamps_r     <= lamp_nxt;
      out_unlocked_r  <= (mode_nxt == tdcl_pkg::MODE_OPEN);
      out_rejecting_r <= (mode_nxt == tdcl_pkg::MODE_REJ_DARK) ||
                         (mode_nxt == tdcl_pkg::MODE_REJ_FLASH) ||
                         (mode_nxt == tdcl_pkg::MODE_REJ_PAUSE);
      out_digits_r    <= position_nxt;
      out_digit_r     <= selected_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.lamps          = out_lamps_r;
  assign out_if.unlocked       = out_unlocked_r;
  assign out_if.rejecting      = out_rejecting_r;
  assign out_if.digits_entered = out_digits_r;
  assign out_if.current_digit  = out_digit_r;

endmodule

`default_nettype wire

// ===== rtl/tdcl_checker.sv =====
`default_nettype none

module tdcl_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [tdcl_pkg::LAMP_W-1:0]      out_lamps,
  input wire                             out_unlocked,
  input wire                             out_rejecting,
  input wire [tdcl_pkg::POS_W-1:0]       out_digits_entered
);

  // a held item stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_open_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unlocked |-> out_lamps == tdcl_pkg::ALL_LIT)
    else $error("open display without all lamps lit");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_unlocked && out_rejecting))
    else $error("unlocked and rejecting at once");

  a_reject_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejecting |->
      out_lamps == tdcl_pkg::ALL_LIT || out_lamps == tdcl_pkg::ALL_DARK)
    else $error("reject sequence shows a partial lamp pattern");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digits_entered != tdcl_pkg::POS_W'(tdcl_pkg::CODE_LENGTH))
    else $error("digit count reached the code length");

endmodule

bind three_digit_code_lock tdcl_checker u_tdcl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_lamps          (out_if.lamps),
  .out_unlocked       (out_if.unlocked),
  .out_rejecting      (out_if.rejecting),
  .out_digits_entered (out_if.digits_entered)
);

`default_nettype wire
